/* src/hsm_pkg.sv */
`default_nettype none

package hsm_pkg;

	// Table geometry, fixed by the 8-bit handle and slot fields
	localparam int unsigned MAX_ENTRIES = 256;
	localparam int unsigned IDX_W       = 8;
	localparam int unsigned COUNT_W     = 9;

	// Command codes
	localparam logic [2:0] CMD_REGISTER   = 3'd0;
	localparam logic [2:0] CMD_UNREGISTER = 3'd1;
	localparam logic [2:0] CMD_UPDATE     = 3'd2;
	localparam logic [2:0] CMD_LOOKUP     = 3'd3;
	localparam logic [2:0] CMD_CLEAR      = 3'd4;

	// Result status codes
	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_INVALID = 2'd1;
	localparam logic [1:0] STAT_FULL    = 2'd2;

	// Sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_EXEC
	} state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic accept;   // capture item, read handle map, slot map and free stack top
		logic read;     // read key and shader store
		logic exec;     // commit writes and load the result register
	} ctrl_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic out_busy; // result register still held by the sink
	} dp_stat_t;

endpackage

`default_nettype wire

/* src/hsm_ctrl.sv */
`default_nettype none

module hsm_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire hsm_pkg::dp_stat_t stat,
	output hsm_pkg::ctrl_cmd_t    cmd
);
	import hsm_pkg::*;

	state_t state_q;
	state_t state_nxt;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_nxt = ST_READ;
				end
			end
			ST_READ: begin
				state_nxt = ST_EXEC;
			end
			ST_EXEC: begin
				// hold until the result register is free
				if (!stat.out_busy) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// Outputs
	always_comb begin
		in_ready   = 1'b0;
		cmd.accept = 1'b0;
		cmd.read   = 1'b0;
		cmd.exec   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
			end
			ST_READ: begin
				cmd.read = 1'b1;
			end
			ST_EXEC: begin
				cmd.exec = !stat.out_busy;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

`default_nettype wire

/* src/hsm_datapath.sv */
`default_nettype none

module hsm_datapath (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire hsm_pkg::ctrl_cmd_t cmd,
	input  wire logic [2:0]         in_command,
	input  wire logic [7:0]         in_handle,
	input  wire logic signed [15:0] in_sort_key,
	input  wire logic [15:0]        in_shader_tag,
	input  wire logic               out_ready,
	output hsm_pkg::dp_stat_t       stat,
	output logic                    out_valid,
	output logic [1:0]              out_status,
	output logic [7:0]              out_handle,
	output logic [7:0]              out_slot,
	output logic                    out_dirty,
	output logic [8:0]              out_live
);
	import hsm_pkg::*;

	// Stores
	logic [IDX_W-1:0]  h2s_mem    [MAX_ENTRIES];
	logic [IDX_W-1:0]  s2h_mem    [MAX_ENTRIES];
	logic [IDX_W-1:0]  fs_mem     [MAX_ENTRIES];
	logic signed [15:0] key_mem   [MAX_ENTRIES];
	logic [15:0]       shader_mem [MAX_ENTRIES];
	logic [MAX_ENTRIES-1:0] valid_q;

	// Counters and flag
	logic [COUNT_W-1:0] free_depth_q;
	logic [COUNT_W-1:0] issued_q;
	logic [COUNT_W-1:0] entry_count_q;
	logic               dirty_q;

	// Captured item
	logic [2:0]         cmd_q;
	logic [IDX_W-1:0]   h_q;
	logic signed [15:0] key_q;
	logic [15:0]        tag_q;

	// Registered read data
	logic [IDX_W-1:0]   h2s_rd_q;
	logic [IDX_W-1:0]   s2h_rd_q;
	logic [IDX_W-1:0]   fs_rd_q;
	logic signed [15:0] key_rd_q;
	logic [15:0]        shader_rd_q;

	// Result register
	logic               out_valid_q;
	logic [1:0]         status_q;
	logic [IDX_W-1:0]   hout_q;
	logic [IDX_W-1:0]   slot_q;
	logic               dirty_out_q;
	logic [COUNT_W-1:0] live_q;

	// Decoded operation
	logic [IDX_W-1:0]   last_idx;
	logic [IDX_W-1:0]   free_top;
	logic [IDX_W-1:0]   key_rd_addr;
	logic               full;
	logic               live;
	logic               do_reg;
	logic               do_unreg;
	logic               do_move;
	logic               do_upd;
	logic               reuse;
	logic [IDX_W-1:0]   new_handle;
	logic [IDX_W-1:0]   new_slot;
	logic               changed;

	// Next values and result
	logic [COUNT_W-1:0] entry_nxt;
	logic               dirty_nxt;
	logic [1:0]         status_nxt;
	logic [IDX_W-1:0]   hout_nxt;
	logic [IDX_W-1:0]   slot_nxt;

	// Memory write ports
	logic               h2s_we;
	logic [IDX_W-1:0]   h2s_wa;
	logic [IDX_W-1:0]   h2s_wd;
	logic               s2h_we;
	logic [IDX_W-1:0]   s2h_wa;
	logic [IDX_W-1:0]   s2h_wd;
	logic               fs_we;
	logic               kv_we;
	logic [IDX_W-1:0]   kv_wa;
	logic signed [15:0] key_wd;
	logic [15:0]        shader_wd;

	assign last_idx    = IDX_W'(entry_count_q - COUNT_W'(1));
	assign free_top    = IDX_W'(free_depth_q - COUNT_W'(1));
	assign key_rd_addr = (cmd_q == CMD_UPDATE) ? h2s_rd_q : last_idx;

	assign full     = (entry_count_q == COUNT_W'(MAX_ENTRIES));
	assign live     = valid_q[h_q] && ({1'b0, h_q} < issued_q);
	assign do_reg   = cmd.exec && (cmd_q == CMD_REGISTER) && !full;
	assign do_unreg = cmd.exec && (cmd_q == CMD_UNREGISTER) && live;
	assign do_move  = do_unreg && (h2s_rd_q != last_idx);
	assign do_upd   = cmd.exec && (cmd_q == CMD_UPDATE) && live;

	assign reuse      = (free_depth_q != '0);
	assign new_handle = reuse ? fs_rd_q : IDX_W'(issued_q);
	assign new_slot   = IDX_W'(entry_count_q);
	assign changed    = (key_rd_q != key_q) || (shader_rd_q != tag_q);

	// Item capture
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			cmd_q <= in_command;
			h_q   <= in_handle;
			key_q <= in_sort_key;
			tag_q <= in_shader_tag;
		end
	end

	// First reads: handle map, slot map at last slot, free stack top
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			h2s_rd_q <= h2s_mem[in_handle];
			s2h_rd_q <= s2h_mem[last_idx];
			fs_rd_q  <= fs_mem[free_top];
		end
	end

	// Second read: key and shader at the handle's slot or at the last slot
	always_ff @(posedge clk) begin
		if (cmd.read) begin
			key_rd_q    <= key_mem[key_rd_addr];
			shader_rd_q <= shader_mem[key_rd_addr];
		end
	end

	// Write port selection
	always_comb begin
		h2s_we    = do_reg || do_move;
		h2s_wa    = do_reg ? new_handle : s2h_rd_q;
		h2s_wd    = do_reg ? new_slot : h2s_rd_q;
		s2h_we    = do_reg || do_move;
		s2h_wa    = do_reg ? new_slot : h2s_rd_q;
		s2h_wd    = do_reg ? new_handle : s2h_rd_q;
		fs_we     = do_unreg && !free_depth_q[COUNT_W-1];
		kv_we     = do_reg || do_move || do_upd;
		kv_wa     = do_reg ? new_slot : h2s_rd_q;
		key_wd    = key_q;
		shader_wd = tag_q;
		if (do_reg) begin
			key_wd    = '0;
			shader_wd = '0;
		end else if (do_move) begin
			key_wd    = key_rd_q;
			shader_wd = shader_rd_q;
		end
	end

	// Memory writes
	always_ff @(posedge clk) begin
		if (h2s_we) begin
			h2s_mem[h2s_wa] <= h2s_wd;
		end
		if (s2h_we) begin
			s2h_mem[s2h_wa] <= s2h_wd;
		end
		if (fs_we) begin
			fs_mem[IDX_W'(free_depth_q)] <= h_q;
		end
		if (kv_we) begin
			key_mem[kv_wa]    <= key_wd;
			shader_mem[kv_wa] <= shader_wd;
		end
	end

	// Result of the operation
	always_comb begin
		entry_nxt  = entry_count_q;
		dirty_nxt  = dirty_q;
		status_nxt = STAT_OK;
		hout_nxt   = h_q;
		slot_nxt   = '0;
		case (cmd_q)
			CMD_REGISTER: begin
				if (full) begin
					status_nxt = STAT_FULL;
				end else begin
					entry_nxt = entry_count_q + COUNT_W'(1);
					dirty_nxt = 1'b1;
					hout_nxt  = new_handle;
					slot_nxt  = new_slot;
				end
			end
			CMD_UNREGISTER: begin
				if (!live) begin
					status_nxt = STAT_INVALID;
				end else begin
					entry_nxt = entry_count_q - COUNT_W'(1);
					dirty_nxt = 1'b1;
				end
			end
			CMD_UPDATE: begin
				if (!live) begin
					status_nxt = STAT_INVALID;
				end else begin
					dirty_nxt = dirty_q || changed;
					slot_nxt  = h2s_rd_q;
				end
			end
			CMD_LOOKUP: begin
				if (!live) begin
					status_nxt = STAT_INVALID;
				end else begin
					slot_nxt = h2s_rd_q;
				end
			end
			CMD_CLEAR: begin
				dirty_nxt = 1'b0;
			end
			default: begin
				status_nxt = STAT_INVALID;
			end
		endcase
	end

	// Counters, flag and handle valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_depth_q  <= '0;
			issued_q      <= '0;
			entry_count_q <= '0;
			dirty_q       <= 1'b0;
			valid_q       <= '0;
		end else if (cmd.exec) begin
			entry_count_q <= entry_nxt;
			dirty_q       <= dirty_nxt;
			if (do_reg) begin
				valid_q[new_handle] <= 1'b1;
				if (reuse) begin
					free_depth_q <= free_depth_q - COUNT_W'(1);
				end else begin
					issued_q <= issued_q + COUNT_W'(1);
				end
			end
			if (do_unreg) begin
				valid_q[h_q] <= 1'b0;
				if (fs_we) begin
					free_depth_q <= free_depth_q + COUNT_W'(1);
				end
			end
		end
	end

	// Result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.exec) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result register payload
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			status_q    <= status_nxt;
			hout_q      <= hout_nxt;
			slot_q      <= slot_nxt;
			dirty_out_q <= dirty_nxt;
			live_q      <= entry_nxt;
		end
	end

	assign stat.out_busy = out_valid_q && !out_ready;
	assign out_valid     = out_valid_q;
	assign out_status    = status_q;
	assign out_handle    = hout_q;
	assign out_slot      = slot_q;
	assign out_dirty     = dirty_out_q;
	assign out_live      = live_q;

endmodule

`default_nettype wire

/* src/handle_slot_map_swap_remove_top.sv */
// Channel | Dir | Signals                     | Contents
// s_*     | in  | tvalid tready tdata[39:0]   | handle, sort_key, shader_tag
//         |     | tuser[2:0]                  | command
// m_*     | out | tvalid tready tdata[31:0]   | handle_out, slot_index,
//         |     | tuser[1:0]                  | order_dirty, live_count; status
//
// Every command runs in order: capture with the handle map, slot map and
// free stack reads, then the key and shader store read, then the write-back.
// For an update the key store read is addressed through the handle map read.
// The result sits in an output register; a stalled sink holds the write-back.
// Reset is asynchronous; the handle valid bits clear at once, no clearing pass.
`default_nettype none

module handle_slot_map_swap_remove_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [39:0] s_tdata,  // handle[7:0], sort_key[23:8], shader_tag[39:24]
	input  wire logic [2:0]  s_tuser,  // command[2:0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,  // handle_out[7:0], slot_index[15:8],
	                                   // order_dirty[16], live_count[25:17], zero[31:26]
	output logic [1:0]       m_tuser   // status[1:0]
);
	import hsm_pkg::*;

	ctrl_cmd_t   ctrl_cmd;
	dp_stat_t    dp_stat;
	logic [1:0]  out_status;
	logic [7:0]  out_handle;
	logic [7:0]  out_slot;
	logic        out_dirty;
	logic [8:0]  out_live;

	hsm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.stat     (dp_stat),
		.cmd      (ctrl_cmd)
	);

	hsm_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (ctrl_cmd),
		.in_command    (s_tuser),
		.in_handle     (s_tdata[7:0]),
		.in_sort_key   (s_tdata[23:8]),
		.in_shader_tag (s_tdata[39:24]),
		.out_ready     (m_tready),
		.stat          (dp_stat),
		.out_valid     (m_tvalid),
		.out_status    (out_status),
		.out_handle    (out_handle),
		.out_slot      (out_slot),
		.out_dirty     (out_dirty),
		.out_live      (out_live)
	);

	// Output packing
	assign m_tuser = out_status;
	assign m_tdata = {6'd0, out_live, out_dirty, out_slot, out_handle};

`ifndef SYNTHESIS
	// An accepted item always moves on to the store read
	a_accept_then_read: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl_cmd.accept |=> ctrl_cmd.read)
		else $error("store read did not follow item capture");

	// Sequencer phases never overlap
	a_phases_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({ctrl_cmd.accept, ctrl_cmd.read, ctrl_cmd.exec}))
		else $error("sequencer phases overlap");

	// A full status only comes with a full table
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser == STAT_FULL)) |-> (m_tdata[25:17] == 9'd256))
		else $error("full status with table not full");

	// Live count never exceeds the table size
	a_live_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[25] && (m_tdata[24:17] != 8'd0)))
		else $error("live count beyond table size");
`endif

endmodule

`default_nettype wire

/* bench/handle_slot_map_swap_remove_top_tb.sv */
`timescale 1ns / 1ps

module handle_slot_map_swap_remove_top_tb;

	import hsm_pkg::*;

	// Codes with no meaning to the block; they must come back as invalid
	localparam logic [2:0] CMD_SPARE_A = 3'd5;
	localparam logic [2:0] CMD_SPARE_B = 3'd6;
	localparam logic [2:0] CMD_SPARE_C = 3'd7;

	typedef enum logic [1:0] {
		TREND_GROW,
		TREND_SHRINK,
		TREND_STEADY
	} fill_trend_t;

	typedef struct packed {
		logic [1:0] status;
		logic [7:0] handle_out;
		logic [7:0] slot_index;
		logic       order_dirty;
		logic [8:0] live_count;
	} map_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata = '0;   // handle[7:0], sort_key[23:8], shader_tag[39:24]
	logic [2:0]  s_tuser = '0;   // command[2:0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;        // handle_out[7:0], slot_index[15:8], order_dirty[16],
	                             // live_count[25:17], zero[31:26]
	logic [1:0]  m_tuser;        // status[1:0]

	// Shadow copy of the slot map
	logic        map_live [MAX_ENTRIES] = '{default: 1'b0};
	logic [8:0]  map_slot [MAX_ENTRIES] = '{default: '0};
	logic [7:0]  slot_owner [MAX_ENTRIES] = '{default: '0};
	logic [7:0]  free_handles [MAX_ENTRIES] = '{default: '0};
	logic [15:0] slot_sort_key [MAX_ENTRIES] = '{default: '0};
	logic [15:0] slot_shader_tag [MAX_ENTRIES] = '{default: '0};
	logic [8:0]  free_top = '0;
	logic [8:0]  issued_count = '0;
	logic [8:0]  entry_total = '0;
	logic        order_dirty_flag = 1'b0;

	map_result_t slot_map_replies[$];
	int unsigned error_count = 0;
	bit          idle_on = 1'b1;
	int unsigned sink_hold_cycles = 0;

	handle_slot_map_swap_remove_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		#2_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	task automatic report_mismatch(input string what);
		$display("%0t: mismatch: %s", $time, what);
		error_count++;
	endtask

	// Apply one command to the shadow map and return the reply it should give
	function automatic map_result_t predict_slot_map(input logic [2:0] cmd,
			input logic [7:0] hnd, input logic [15:0] key, input logic [15:0] tag);
		map_result_t r;
		logic [8:0]  idx;
		logic [8:0]  last_slot;
		logic [7:0]  new_handle;
		logic [7:0]  moved_handle;
		r.status     = STAT_OK;
		r.handle_out = hnd;
		r.slot_index = '0;
		case (cmd)
			CMD_REGISTER: begin
				if (entry_total >= MAX_ENTRIES) begin
					r.status = STAT_FULL;
				end else begin
					// most recently freed handle first, else a fresh one
					if (free_top != 0) begin
						free_top--;
						new_handle = free_handles[free_top[7:0]];
					end else begin
						new_handle = issued_count[7:0];
						issued_count++;
					end
					idx = entry_total;
					map_live[new_handle] = 1'b1;
					map_slot[new_handle] = idx;
					slot_owner[idx[7:0]] = new_handle;
					slot_sort_key[idx[7:0]] = '0;
					slot_shader_tag[idx[7:0]] = '0;
					entry_total++;
					order_dirty_flag = 1'b1;
					r.handle_out = new_handle;
					r.slot_index = idx[7:0];
				end
			end
			CMD_UNREGISTER, CMD_UPDATE, CMD_LOOKUP: begin
				idx = map_slot[hnd];
				if (!(hnd < issued_count && map_live[hnd] && idx < entry_total)) begin
					r.status = STAT_INVALID;
				end else if (cmd == CMD_UNREGISTER) begin
					// swap-remove: last slot fills the hole
					last_slot = entry_total - 1'b1;
					if (idx != last_slot) begin
						moved_handle = slot_owner[last_slot[7:0]];
						slot_sort_key[idx[7:0]] = slot_sort_key[last_slot[7:0]];
						slot_shader_tag[idx[7:0]] = slot_shader_tag[last_slot[7:0]];
						slot_owner[idx[7:0]] = moved_handle;
						map_slot[moved_handle] = idx;
					end
					entry_total = last_slot;
					map_live[hnd] = 1'b0;
					map_slot[hnd] = '0;
					if (free_top < MAX_ENTRIES) begin
						free_handles[free_top[7:0]] = hnd;
						free_top++;
					end
					order_dirty_flag = 1'b1;
				end else if (cmd == CMD_UPDATE) begin
					if (slot_sort_key[idx[7:0]] != key || slot_shader_tag[idx[7:0]] != tag)
						order_dirty_flag = 1'b1;
					slot_sort_key[idx[7:0]] = key;
					slot_shader_tag[idx[7:0]] = tag;
					r.slot_index = idx[7:0];
				end else begin
					r.slot_index = idx[7:0];
				end
			end
			CMD_CLEAR: begin
				order_dirty_flag = 1'b0;
			end
			default: begin
				r.status = STAT_INVALID;
			end
		endcase
		r.order_dirty = order_dirty_flag;
		r.live_count  = entry_total;
		return r;
	endfunction

	// Offer one item, hold it until taken, then log the reply it should give
	task automatic send_item(input logic [2:0] cmd, input logic [7:0] hnd,
			input logic [15:0] key, input logic [15:0] tag);
		int unsigned gap;
		if (idle_on && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 15);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {tag, key, hnd};
		s_tuser  <= cmd;
		do @(posedge clk); while (!s_tready);
		slot_map_replies.insert(slot_map_replies.size(),
			predict_slot_map(cmd, hnd, key, tag));
	endtask

	// Mostly well-formed commands on live handles, with some noise mixed in
	task automatic send_random_command(input fill_trend_t trend);
		int unsigned roll;
		int unsigned reg_pct;
		int unsigned unreg_pct;
		logic [2:0]  cmd;
		logic [7:0]  hnd;
		logic [15:0] key;
		logic [15:0] tag;
		roll = $urandom_range(0, 99);
		hnd  = 8'($urandom);
		key  = 16'($urandom);
		tag  = 16'($urandom);
		case (trend)
			TREND_GROW: begin
				reg_pct = 50;
				unreg_pct = 15;
			end
			TREND_SHRINK: begin
				reg_pct = 15;
				unreg_pct = 50;
			end
			default: begin
				reg_pct = 30;
				unreg_pct = 25;
			end
		endcase
		if (entry_total != 0 && $urandom_range(0, 9) != 0)
			hnd = slot_owner[$urandom_range(0, entry_total - 1)];
		if (roll < reg_pct) begin
			cmd = CMD_REGISTER;
		end else if (roll < reg_pct + unreg_pct) begin
			cmd = CMD_UNREGISTER;
		end else if (roll < reg_pct + unreg_pct + 20) begin
			cmd = CMD_UPDATE;
			// same key and tag again must leave the flag alone
			if ($urandom_range(0, 3) == 0) begin
				key = slot_sort_key[map_slot[hnd][7:0]];
				tag = slot_shader_tag[map_slot[hnd][7:0]];
			end else if ($urandom_range(0, 3) == 0) begin
				key = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
			end
		end else if (roll < reg_pct + unreg_pct + 30) begin
			cmd = CMD_LOOKUP;
		end else if (roll < reg_pct + unreg_pct + 36) begin
			cmd = CMD_CLEAR;
		end else begin
			cmd = 3'($urandom);
		end
		send_item(cmd, hnd, key, tag);
	endtask

	// Hand-picked sequence: empty table, swap-remove, handle reuse, flag rules
	task automatic test_directed();
		send_item(CMD_LOOKUP, 8'h00, '0, '0);            // nothing issued yet
		send_item(CMD_UNREGISTER, 8'hFF, '0, '0);
		send_item(CMD_REGISTER, 8'h00, '0, '0);
		send_item(CMD_REGISTER, 8'h00, 16'hFFFF, 16'hFFFF);
		send_item(CMD_REGISTER, 8'hFF, 16'h8000, '0);
		send_item(CMD_CLEAR, 8'h00, '0, '0);
		send_item(CMD_UPDATE, 8'h01, '0, '0);             // unchanged, stays clean
		send_item(CMD_UPDATE, 8'h01, 16'h8000, 16'hFFFF);
		send_item(CMD_CLEAR, 8'hFF, 16'hFFFF, 16'hFFFF);
		send_item(CMD_UPDATE, 8'h02, 16'h7FFF, '0);
		send_item(CMD_CLEAR, 8'h00, '0, '0);
		send_item(CMD_UPDATE, 8'h01, 16'h8000, 16'hFFFF); // unchanged again
		send_item(CMD_LOOKUP, 8'h02, '0, '0);
		send_item(CMD_UNREGISTER, 8'h00, 16'hFFFF, 16'hFFFF); // last slot moves down
		send_item(CMD_LOOKUP, 8'h02, '0, '0);
		send_item(CMD_LOOKUP, 8'h00, '0, '0);             // dead handle
		send_item(CMD_UPDATE, 8'h00, 16'h1234, 16'h5678);
		send_item(CMD_UNREGISTER, 8'h01, '0, '0);         // already last, no move
		send_item(CMD_REGISTER, 8'h00, '0, '0);           // reuses the newest freed
		send_item(CMD_REGISTER, 8'h00, '0, '0);
		send_item(CMD_REGISTER, 8'h00, '0, '0);           // free stack empty: fresh
		send_item(CMD_LOOKUP, 8'h04, '0, '0);             // beyond the issued range
		send_item(CMD_SPARE_A, 8'h01, 16'hFFFF, 16'hFFFF);
		send_item(CMD_SPARE_B, 8'h02, 16'h0000, 16'h0000);
		send_item(CMD_SPARE_C, 8'hFF, 16'hA5A5, 16'h5A5A);
	endtask

	// Fill every slot, bounce off the full table, then empty it in random order
	task automatic test_fill_table();
		while (entry_total < MAX_ENTRIES)
			send_item(CMD_REGISTER, 8'($urandom), 16'($urandom), 16'($urandom));
		send_item(CMD_REGISTER, 8'hFF, 16'hFFFF, 16'hFFFF);
		send_item(CMD_REGISTER, 8'h00, '0, '0);
		send_item(CMD_LOOKUP, 8'hFF, '0, '0);
		send_item(CMD_UPDATE, 8'hFF, 16'h7FFF, 16'hFFFF);
		while (entry_total != 0)
			send_item(CMD_UNREGISTER, slot_owner[$urandom_range(0, entry_total - 1)],
				16'($urandom), 16'($urandom));
		send_item(CMD_UNREGISTER, 8'h00, '0, '0);
		send_item(CMD_LOOKUP, 8'hFF, '0, '0);
	endtask

	// Sink holds off for a long stretch while items keep coming
	task automatic test_backpressure();
		idle_on = 1'b0;
		sink_hold_cycles = 300;
		repeat (40) send_random_command(TREND_STEADY);
		idle_on = 1'b1;
	endtask

	task automatic test_random_mix(input int unsigned count);
		fill_trend_t trend;
		trend = TREND_STEADY;
		for (int unsigned n = 0; n < count; n++) begin
			if (n % 150 == 0) begin
				trend = fill_trend_t'($urandom_range(0, 2));
				idle_on = ($urandom_range(0, 3) != 0);
			end
			send_random_command(trend);
		end
	endtask

	task automatic test_full_rate(input int unsigned count);
		idle_on = 1'b0;
		repeat (count) send_random_command(TREND_STEADY);
	endtask

	// Sink side: random stalls, plus the long hold-off on request
	initial begin : sink_ready
		int unsigned stall;
		forever begin
			@(posedge clk);
			if (sink_hold_cycles != 0) begin
				m_tready <= 1'b0;
				repeat (sink_hold_cycles) @(posedge clk);
				sink_hold_cycles = 0;
				m_tready <= 1'b1;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				stall = $urandom_range(1, 15);
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Compare each reply with the oldest outstanding prediction
	always @(posedge clk) begin : check_replies
		map_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (slot_map_replies.size() == 0) begin
				report_mismatch($sformatf("unexpected reply tdata=%h tuser=%h",
					m_tdata, m_tuser));
			end else begin
				want = slot_map_replies.pop_front();
				if (m_tuser !== want.status)
					report_mismatch($sformatf("status %0d, want %0d", m_tuser, want.status));
				if (m_tdata[7:0] !== want.handle_out)
					report_mismatch($sformatf("handle_out %0d, want %0d",
						m_tdata[7:0], want.handle_out));
				if (m_tdata[15:8] !== want.slot_index)
					report_mismatch($sformatf("slot_index %0d, want %0d",
						m_tdata[15:8], want.slot_index));
				if (m_tdata[16] !== want.order_dirty)
					report_mismatch($sformatf("order_dirty %b, want %b",
						m_tdata[16], want.order_dirty));
				if (m_tdata[25:17] !== want.live_count)
					report_mismatch($sformatf("live_count %0d, want %0d",
						m_tdata[25:17], want.live_count));
				if (m_tdata[31:26] !== '0)
					report_mismatch($sformatf("padding bits %b not zero", m_tdata[31:26]));
			end
		end
	end

	initial begin : run_tests
		int unsigned drain_wait;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_fill_table();
		test_backpressure();
		test_random_mix(920);
		test_full_rate(300);
		s_tvalid <= 1'b0;

		// let the last replies come out
		drain_wait = 0;
		while (slot_map_replies.size() != 0 && drain_wait < 20000) begin
			@(posedge clk);
			drain_wait++;
		end
		if (slot_map_replies.size() != 0)
			report_mismatch($sformatf("%0d replies never arrived", slot_map_replies.size()));
		repeat (10) @(posedge clk);

		if (error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

/* sim.f */
src/hsm_pkg.sv
src/hsm_ctrl.sv
src/hsm_datapath.sv
src/handle_slot_map_swap_remove_top.sv
bench/handle_slot_map_swap_remove_top_tb.sv
